FILE: rtl/qalu_pkg.sv
package qalu_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_ROT   = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;
    localparam logic [2:0] OP_DOT   = 3'd5;
    localparam logic [2:0] OP_EQ    = 3'd6;
    localparam logic [2:0] OP_NEG   = 3'd7;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
    } t_req;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_w;
        logic               is_equal;
        logic               saturated;
    } t_res;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat sat33(input logic signed [32:0] v);
        t_sat s;
        s.sat = (v[32] != v[31]);
        if (!s.sat) begin
            s.val = v[31:0];
        end else if (v[32]) begin
            s.val = Q_MIN;
        end else begin
            s.val = Q_MAX;
        end
        return s;
    endfunction

endpackage

FILE: rtl/qalu_prod.sv
module qalu_prod #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [32:0]            i_l [4],
    input  logic signed [32:0]            i_r [4],
    output logic signed [63-FRAC_BITS:0]  o_p [16]
);

    localparam int PW = 64 - FRAC_BITS;

    logic signed [65:0]   w_full [16];
    logic signed [65:0]   w_shift [16];
    logic signed [PW-1:0] r_p [16];

    // all sixteen pairwise products, floored after the fraction shift
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_full[i*4+j]  = 66'(i_l[i]) * 66'(i_r[j]);
                w_shift[i*4+j] = w_full[i*4+j] >>> FRAC_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 16; k++) begin
                r_p[k] <= w_shift[k][PW-1:0];
            end
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/quaternion_alu.sv
// channel | signals                                  | direction
// request | i_in_valid, o_in_ready, i_in_data (t_req) | in
// result  | o_out_valid, i_out_ready, o_out_data (t_res) | out
//
// one request per cycle while the result channel is not stalled; four-stage pipeline
// stages: products of a and b, hamilton sums, products with conj(a), final sums
// each stage holds its item while the next one is full and stalled
// synchronous active-low reset clears only the stage valid bits
module quaternion_alu
    import qalu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_out_data
);

    localparam int PW = 64 - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] SMAX = SW'(Q_MAX);
    localparam logic signed [SW-1:0] SMIN = SW'(Q_MIN);

    function automatic t_sat sat_sw(input logic signed [SW-1:0] v);
        t_sat s;
        if (v > SMAX) begin
            s.sat = 1'b1;
            s.val = Q_MAX;
        end else if (v < SMIN) begin
            s.sat = 1'b1;
            s.val = Q_MIN;
        end else begin
            s.sat = 1'b0;
            s.val = v[31:0];
        end
        return s;
    endfunction

    // p[i*4+j] = l[i]*r[j], component order x, y, z, w
    function automatic logic signed [SW-1:0] ham_sum(
        input logic signed [PW-1:0] p [16],
        input logic [1:0]           k
    );
        logic signed [SW-1:0] s;
        case (k)
            2'd0: s = SW'(p[12]) + SW'(p[3]) + SW'(p[6]) - SW'(p[9]);
            2'd1: s = SW'(p[13]) + SW'(p[7]) + SW'(p[8]) - SW'(p[2]);
            2'd2: s = SW'(p[14]) + SW'(p[11]) + SW'(p[1]) - SW'(p[4]);
            default: s = SW'(p[15]) - SW'(p[0]) - SW'(p[5]) - SW'(p[10]);
        endcase
        return s;
    endfunction

    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_v4;
    logic [2:0] r_op1, r_op2, r_op3, r_op4;
    logic signed [31:0] r_a1 [4];
    logic signed [31:0] r_a2 [4];
    t_res r_dir1, r_res2, r_res3, r_out;
    t_res n_dir1, n_res2, n_out;

    logic signed [31:0] w_a [4];
    logic signed [31:0] w_b [4];
    logic signed [32:0] w_l1 [4];
    logic signed [32:0] w_r1 [4];
    logic signed [32:0] w_l2 [4];
    logic signed [32:0] w_r2 [4];
    logic signed [PW-1:0] w_p1 [16];
    logic signed [PW-1:0] w_p2 [16];
    t_sat w_d [4];
    t_sat w_h [4];
    t_sat w_sc [4];
    t_sat w_dot;
    t_sat w_f [3];

    assign en4 = !r_v4 || i_out_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: first products and the direct operations
    always_comb begin
        w_a[0] = i_in_data.a_x;
        w_a[1] = i_in_data.a_y;
        w_a[2] = i_in_data.a_z;
        w_a[3] = i_in_data.a_w;
        w_b[0] = i_in_data.b_x;
        w_b[1] = i_in_data.b_y;
        w_b[2] = i_in_data.b_z;
        w_b[3] = i_in_data.b_w;
        for (int i = 0; i < 4; i++) begin
            w_l1[i] = 33'(w_a[i]);
            w_r1[i] = 33'(w_b[i]);
        end
        // rotate uses the pure vector (b.xyz, 0)
        if (i_in_data.req_type == OP_ROT) w_r1[3] = '0;
        for (int i = 0; i < 4; i++) begin
            case (i_in_data.req_type)
                OP_ADD:  w_d[i] = sat33(33'(w_a[i]) + 33'(w_b[i]));
                OP_SUB:  w_d[i] = sat33(33'(w_a[i]) - 33'(w_b[i]));
                OP_NEG:  w_d[i] = sat33(-33'(w_a[i]));
                default: w_d[i] = '0;
            endcase
        end
        n_dir1.r_x       = w_d[0].val;
        n_dir1.r_y       = w_d[1].val;
        n_dir1.r_z       = w_d[2].val;
        n_dir1.r_w       = w_d[3].val;
        n_dir1.saturated = w_d[0].sat | w_d[1].sat | w_d[2].sat | w_d[3].sat;
        n_dir1.is_equal  = (i_in_data.req_type == OP_EQ)
                        && (w_a[0] == w_b[0]) && (w_a[1] == w_b[1])
                        && (w_a[2] == w_b[2]) && (w_a[3] == w_b[3]);
    end

    qalu_prod #(
        .FRAC_BITS(FRAC_BITS)
    ) u_prod1 (
        .i_clk(i_clk),
        .i_en (en1),
        .i_l  (w_l1),
        .i_r  (w_r1),
        .o_p  (w_p1)
    );

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op1  <= i_in_data.req_type;
            r_a1   <= w_a;
            r_dir1 <= n_dir1;
        end
    end

    // stage 2: hamilton sums, scale, dot
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_h[k]  = sat_sw(ham_sum(w_p1, 2'(k)));
            w_sc[k] = sat_sw(SW'(w_p1[k*4+3]));
        end
        w_dot = sat_sw(SW'(w_p1[0]) + SW'(w_p1[5]) + SW'(w_p1[10]) + SW'(w_p1[15]));
        n_res2 = r_dir1;
        case (r_op1)
            OP_MUL, OP_ROT: begin
                n_res2.r_x       = w_h[0].val;
                n_res2.r_y       = w_h[1].val;
                n_res2.r_z       = w_h[2].val;
                n_res2.r_w       = w_h[3].val;
                n_res2.saturated = w_h[0].sat | w_h[1].sat | w_h[2].sat | w_h[3].sat;
            end
            OP_SCALE: begin
                n_res2.r_x       = w_sc[0].val;
                n_res2.r_y       = w_sc[1].val;
                n_res2.r_z       = w_sc[2].val;
                n_res2.r_w       = w_sc[3].val;
                n_res2.saturated = w_sc[0].sat | w_sc[1].sat | w_sc[2].sat | w_sc[3].sat;
            end
            OP_DOT: begin
                n_res2.r_x       = w_dot.val;
                n_res2.r_y       = '0;
                n_res2.r_z       = '0;
                n_res2.r_w       = '0;
                n_res2.saturated = w_dot.sat;
            end
            default: n_res2 = r_dir1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_op2  <= r_op1;
            r_a2   <= r_a1;
            r_res2 <= n_res2;
        end
    end

    // stage 3: intermediate times conj(a)
    always_comb begin
        w_l2[0] = 33'(r_res2.r_x);
        w_l2[1] = 33'(r_res2.r_y);
        w_l2[2] = 33'(r_res2.r_z);
        w_l2[3] = 33'(r_res2.r_w);
        for (int i = 0; i < 3; i++) begin
            w_r2[i] = -33'(r_a2[i]);
        end
        w_r2[3] = 33'(r_a2[3]);
    end

    qalu_prod #(
        .FRAC_BITS(FRAC_BITS)
    ) u_prod2 (
        .i_clk(i_clk),
        .i_en (en3),
        .i_l  (w_l2),
        .i_r  (w_r2),
        .o_p  (w_p2)
    );

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_op3  <= r_op2;
            r_res3 <= r_res2;
        end
    end

    // stage 4: rotated vector sums
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_f[k] = sat_sw(ham_sum(w_p2, 2'(k)));
        end
        n_out = r_res3;
        if (r_op3 == OP_ROT) begin
            n_out.r_x       = w_f[0].val;
            n_out.r_y       = w_f[1].val;
            n_out.r_z       = w_f[2].val;
            n_out.r_w       = '0;
            n_out.saturated = r_res3.saturated | w_f[0].sat | w_f[1].sat | w_f[2].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_op4 <= r_op3;
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("accepted request did not enter stage 1");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en3) |=> (r_v2 && $stable(r_op2) && $stable(r_res2)))
        else $error("stalled stage 2 item changed");

    a_equal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_equal) |->
        (r_op4 == OP_EQ && !o_out_data.saturated && o_out_data.r_x == 0))
        else $error("equal flag on wrong result");

    a_rot_w_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_op4 == OP_ROT) |-> (o_out_data.r_w == 0))
        else $error("rotate result has nonzero w");

endmodule
